>>> hw/rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// shared types and constants of the rgb/hsv color converter
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int COLOR_W  = 8;
    localparam int HUE_W    = 13;
    localparam int HNUM_W   = 21;
    localparam int SNUM_W   = 16;
    localparam int HQ_BITS  = 13;
    localparam int SQ_BITS  = 8;
    localparam int DIV_LAST = HQ_BITS;

    localparam logic [HUE_W-1:0] HUE_SECTOR = 13'd960;
    localparam logic [HUE_W-1:0] HUE_TURN   = 13'd5760;
    localparam logic [15:0]      RECIP_15   = 16'd34953;

    localparam logic KIND_TO_HSV = 1'b0;
    localparam logic KIND_TO_RGB = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [COLOR_W-1:0] hi;
        logic               c_zero;
        logic               hi_zero;
        logic [COLOR_W-1:0] chroma;
        logic [HNUM_W-1:0]  hrem;
        logic [HQ_BITS-1:0] hquo;
        logic [SNUM_W-1:0]  srem;
        logic [SQ_BITS-1:0] squo;
        logic [HUE_W-1:0]   h;
        logic [COLOR_W-1:0] v;
        logic [15:0]        prod;
        logic [COLOR_W-1:0] p;
        logic [COLOR_W-1:0] q;
        logic [2:0]         k;
        logic [17:0]        y;
    } pipe_t;

endpackage

>>> hw/rtl/rgb_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_hsv_converter
// pipelined rgb to hsv and hsv to rgb converter; without a stall, one word per clock
// ----------------------------------------------------------------------------
// Takes one word per clock when the output side keeps up and returns each result
// from a registered output. Pipeline depth is set by the hue quotient: a
// restoring divider with one quotient bit per stage over 13 stages, with the
// saturation quotient and the hsv to rgb products worked in the same stages.
// Each stage has its own valid bit, so a stall at the output fills empty
// stages first and only then holds the input side.
module rgb_hsv_converter
    import rhc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [COLOR_W-1:0] red_in,
    input  logic [COLOR_W-1:0] green_in,
    input  logic [COLOR_W-1:0] blue_in,
    input  logic [HUE_W-1:0]   hue_in,
    input  logic [COLOR_W-1:0] sat_in,
    input  logic [COLOR_W-1:0] val_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COLOR_W-1:0] red_out,
    output logic [COLOR_W-1:0] green_out,
    output logic [COLOR_W-1:0] blue_out,
    output logic [HUE_W-1:0]   hue_out,
    output logic [COLOR_W-1:0] sat_out,
    output logic [COLOR_W-1:0] val_out
);

    pipe_t              stage_reg  [DIV_LAST+1];
    pipe_t              stage_next [DIV_LAST+1];
    pipe_t              entry_next;
    logic [DIV_LAST:0]  valid_reg;
    logic [DIV_LAST+1:0] en;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [COLOR_W-1:0] red_reg, green_reg, blue_reg, sat_reg, val_reg;
    logic [HUE_W-1:0]   hue_reg;
    logic [COLOR_W-1:0] red_next, green_next, blue_next, sat_next, val_next;
    logic [HUE_W-1:0]   hue_next;

    // entry stage
    always_comb
    begin
        logic [COLOR_W-1:0] hi, lo, c;
        logic [10:0]        base;
        pipe_t              s;
        hi = red_in;
        lo = red_in;
        if (green_in > hi) hi = green_in;
        if (blue_in > hi)  hi = blue_in;
        if (green_in < lo) lo = green_in;
        if (blue_in < lo)  lo = blue_in;
        c = hi - lo;
        if (red_in == hi)
            base = 11'(6 * c) + 11'(green_in) - 11'(blue_in);
        else if (green_in == hi)
            base = 11'(2 * c) + 11'(blue_in) - 11'(red_in);
        else
            base = 11'(4 * c) + 11'(red_in) - 11'(green_in);
        s         = '0;
        s.kind    = kind;
        s.hi      = hi;
        s.chroma  = c;
        s.c_zero  = (c == '0);
        s.hi_zero = (hi == '0);
        s.hrem    = (HNUM_W'(base) << 10) - (HNUM_W'(base) << 6);
        s.srem    = (SNUM_W'(c) << 8) - SNUM_W'(c);
        s.h       = (hue_in >= HUE_TURN) ? hue_in - HUE_TURN : hue_in;
        s.v       = val_in;
        s.prod    = val_in * sat_in;
        entry_next = s;
    end

    // divide steps, with the hsv to rgb work in the first stages
    always_comb
    begin
        stage_next[0] = entry_next;
        for (int i = 1; i <= DIV_LAST; i++)
        begin
            automatic pipe_t              s = stage_reg[i-1];
            automatic int                 j = DIV_LAST - i;
            automatic logic [HNUM_W-1:0]  hd = HNUM_W'(s.chroma) << j;
            automatic logic [SNUM_W-1:0]  sd = SNUM_W'(s.hi) << (j % SQ_BITS);
            automatic logic [16:0]        x17 = '0;
            automatic logic [HUE_W-1:0]   f = '0;
            automatic logic [10:0]        d = '0;
            automatic logic [27:0]        zq = '0;
            if (s.hrem >= hd)
            begin
                s.hrem    = s.hrem - hd;
                s.hquo[j] = 1'b1;
            end
            if (j < SQ_BITS && s.srem >= sd)
            begin
                s.srem              = s.srem - sd;
                s.squo[j % SQ_BITS] = 1'b1;
            end
            case (i)
                1:
                begin
                    x17 = 17'(s.prod) + 17'(s.prod[15:8]) + 17'd1;
                    s.p = x17[15:8];
                end
                2:
                begin
                    if (s.h >= 13'd4800)      s.k = 3'd5;
                    else if (s.h >= 13'd3840) s.k = 3'd4;
                    else if (s.h >= 13'd2880) s.k = 3'd3;
                    else if (s.h >= 13'd1920) s.k = 3'd2;
                    else if (s.h >= 13'd960)  s.k = 3'd1;
                    else                      s.k = 3'd0;
                    if (s.h >= 13'd3840)      f = s.h - 13'd3840;
                    else if (s.h >= 13'd1920) f = s.h - 13'd1920;
                    else                      f = s.h;
                    d = (f >= HUE_SECTOR) ? 11'(f - HUE_SECTOR) : 11'(HUE_SECTOR - f);
                    s.y = s.p * (11'(HUE_SECTOR) - d);
                end
                3:
                begin
                    zq  = s.y[17:6] * RECIP_15;
                    s.q = zq[26:19];
                end
                default:
                begin
                end
            endcase
            stage_next[i] = s;
        end
    end

    // output assembly
    always_comb
    begin
        pipe_t              s;
        logic [COLOR_W-1:0] m, rr, gg, bb;
        s  = stage_reg[DIV_LAST];
        m  = s.v - s.p;
        rr = '0;
        gg = '0;
        bb = '0;
        case (s.k)
            3'd0:    begin rr = s.p; gg = s.q; end
            3'd1:    begin rr = s.q; gg = s.p; end
            3'd2:    begin gg = s.p; bb = s.q; end
            3'd3:    begin gg = s.q; bb = s.p; end
            3'd4:    begin rr = s.q; bb = s.p; end
            default: begin rr = s.p; bb = s.q; end
        endcase
        if (s.kind == KIND_TO_RGB)
        begin
            red_next   = rr + m;
            green_next = gg + m;
            blue_next  = bb + m;
            hue_next   = '0;
            sat_next   = '0;
            val_next   = '0;
        end
        else
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
            if (s.c_zero)
                hue_next = '0;
            else if (s.hquo >= HUE_TURN)
                hue_next = s.hquo - HUE_TURN;
            else
                hue_next = s.hquo;
            sat_next = s.hi_zero ? '0 : s.squo;
            val_next = s.hi;
        end
    end

    // per-stage advance
    always_comb
    begin
        en[DIV_LAST+1] = !out_valid_reg || out_ready;
        for (int i = DIV_LAST; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= in_valid;
            for (int i = 1; i <= DIV_LAST; i++)
                if (en[i])
                    valid_reg[i] <= valid_reg[i-1];
            if (en[DIV_LAST+1])
                out_valid_reg <= valid_reg[DIV_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DIV_LAST; i++)
            if (en[i])
                stage_reg[i] <= stage_next[i];
        if (en[DIV_LAST+1])
        begin
            out_kind_reg <= stage_reg[DIV_LAST].kind;
            red_reg      <= red_next;
            green_reg    <= green_next;
            blue_reg     <= blue_next;
            hue_reg      <= hue_next;
            sat_reg      <= sat_next;
            val_reg      <= val_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign hue_out   = hue_reg;
    assign sat_out   = sat_reg;
    assign val_out   = val_reg;

`ifndef SYNTH
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> hue_reg < HUE_TURN)
        else $error("hue out of range");

    a_rgb_unused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_TO_RGB |->
            hue_reg == '0 && sat_reg == '0 && val_reg == '0)
        else $error("hsv fields set in rgb word");

    a_hsv_unused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_TO_HSV |->
            red_reg == '0 && green_reg == '0 && blue_reg == '0)
        else $error("rgb fields set in hsv word");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_TO_HSV && val_reg == '0 |->
            sat_reg == '0 && hue_reg == '0)
        else $error("black word with hue or saturation");
`endif

endmodule
